// ===== src/ppt_pkg.sv =====
// ppt_pkg: field widths, reset values, input kinds, tracker modes and
// register indexes for the pattern position tracker.
// No dependencies; compiled first.
package ppt_pkg;

    localparam int PATTERN_DEPTH_DEF = 1024;

    localparam int KIND_W    = 3;
    localparam int POS_W     = 10;
    localparam int ADDR_W    = 10;
    localparam int STATE_W   = 2;
    localparam int CNT_W     = 32;
    localparam int LEN_W     = 11;
    localparam int FAIL_W    = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic             RING_RST = 1'b1;
    localparam int               LEN_RST  = 1024;
    localparam logic [FAIL_W-1:0] MAXF_RST = 8'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_TRACK = 3'd0,
        KIND_START = 3'd1,
        KIND_RESET = 3'd2,
        KIND_WRITE = 3'd3,
        KIND_CLEAR = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        MODE_UNINIT = 3'b001,
        MODE_TRACK  = 3'b010,
        MODE_LOST   = 3'b100
    } mode_t;

    localparam logic [STATE_W-1:0] ST_UNINIT = 2'd0;
    localparam logic [STATE_W-1:0] ST_TRACK  = 2'd1;
    localparam logic [STATE_W-1:0] ST_LOST   = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RING = 2'd0,
        REG_LEN  = 2'd1,
        REG_MAXF = 2'd2
    } reg_idx_t;

endpackage

// ===== src/ppt_if.sv =====
// ppt_req_if and ppt_rsp_if: valid/ready channels carrying the tracker
// input items and result items. Depends on ppt_pkg for field widths.
interface ppt_req_if
    import ppt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic              sensed_bit;
    logic              direction;
    logic [POS_W-1:0]  start_position;
    logic [ADDR_W-1:0] pattern_address;
    logic              pattern_value;

    modport source (
        output valid, kind, sensed_bit, direction, start_position,
               pattern_address, pattern_value,
        input  ready
    );
    modport sink (
        input  valid, kind, sensed_bit, direction, start_position,
               pattern_address, pattern_value,
        output ready
    );
endinterface

interface ppt_rsp_if
    import ppt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               valid_res;
    logic [POS_W-1:0]   position;
    logic [STATE_W-1:0] tracker_state;
    logic [CNT_W-1:0]   update_total;
    logic [CNT_W-1:0]   match_total;
    logic [CNT_W-1:0]   mismatch_total;

    modport source (
        output valid, valid_res, position, tracker_state, update_total,
               match_total, mismatch_total,
        input  ready
    );
    modport sink (
        input  valid, valid_res, position, tracker_state, update_total,
               match_total, mismatch_total,
        output ready
    );
endinterface

// ===== src/pattern_position_tracker.sv =====
// pattern_position_tracker: follows a position along a stored code pattern.
// Depends on ppt_pkg, ppt_req_if / ppt_rsp_if and ppt_predict.
//
//   channel   | dir | beat contents
//   ----------+-----+-------------------------------------------------------
//   req       | in  | kind, sensed_bit, direction, start_position,
//             |     | pattern_address, pattern_value
//   rsp       | out | valid_res, position, tracker_state, three totals
//   cfg_*     | in  | write enable, register index, write data
//
// one item per cycle unless rsp stalls; input stage, then result stage
// the pattern ram is read as the beat is accepted, at the position predicted
// from the state the previous item leaves, so the compare is one stage later
// a stalled result holds the stage; a new beat still enters while it is empty
// reset clears tracker state, counters and registers; the pattern ram is not
// cleared and holds undefined data until written
module pattern_position_tracker
    import ppt_pkg::*;
#(
    parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    ppt_req_if.sink              req,
    ppt_rsp_if.source            rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int IW = $clog2(PATTERN_DEPTH);
    localparam int LW = $clog2(PATTERN_DEPTH + 1);
    localparam int CW = (LW > LEN_W) ? LW : LEN_W;
    localparam int LEN_RST_EFF = (LEN_RST > PATTERN_DEPTH) ? PATTERN_DEPTH : LEN_RST;
    localparam logic [IW-1:0] LAST_RST = IW'(LEN_RST_EFF - 1);
    localparam logic [IW-1:0] LAST_MAX = IW'(PATTERN_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(PATTERN_DEPTH);

    // configuration
    logic              ring_reg;
    logic [IW-1:0]     last_reg;
    logic [FAIL_W-1:0] maxf_reg;
    logic [CW-1:0]     cfg_len;
    logic [IW-1:0]     cfg_last;
    logic              len_wr;

    // tracker state
    mode_t             mode_reg, mode_next;
    logic [IW-1:0]     cur_reg, cur_next, cur_upd;
    logic [FAIL_W-1:0] frun_reg, frun_next;
    logic [CNT_W-1:0]  upd_reg, upd_next;
    logic [CNT_W-1:0]  mat_reg, mat_next;
    logic [CNT_W-1:0]  mis_reg, mis_next;

    // input stage
    logic              s1_valid_reg;
    logic [KIND_W-1:0] s1_kind_reg;
    logic              s1_bit_reg;
    logic [POS_W-1:0]  s1_start_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_pval_reg;
    logic [IW-1:0]     s1_pred_reg;
    logic              rd_bit_reg;
    logic              byp_hit_reg;
    logic              byp_bit_reg;

    // result stage
    logic              rsp_valid_reg;
    logic              vres_reg, vres_next;

    logic              acc;
    logic              fire;
    logic              exp_bit;
    logic              wr_en;
    logic [IW-1:0]     waddr;
    logic [IW-1:0]     pred;
    logic [IW-1:0]     start_clamped;
    logic [FAIL_W-1:0] frun_inc;

    logic pattern_ram [PATTERN_DEPTH];

    assign fire      = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || fire;
    assign acc       = req.valid && req.ready;

    // effective length minus one, taken when the register is written
    assign cfg_len  = CW'(cfg_wdata[LEN_W-1:0]);
    assign cfg_last = (cfg_len == '0)     ? '0 :
                      (cfg_len > DEPTH_C) ? LAST_MAX :
                                            IW'(cfg_len - CW'(1));
    assign len_wr   = cfg_we && (cfg_index == REG_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg <= RING_RST;
            last_reg <= LAST_RST;
            maxf_reg <= MAXF_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RING: ring_reg <= cfg_wdata[0];
                REG_LEN:  last_reg <= cfg_last;
                REG_MAXF: maxf_reg <= cfg_wdata[FAIL_W-1:0];
                default:  ;
            endcase
        end
    end

    // pattern bit at the predicted position, with the write of the same edge
    assign exp_bit       = byp_hit_reg ? byp_bit_reg : rd_bit_reg;
    assign start_clamped = (32'(s1_start_reg) > 32'(last_reg)) ? last_reg : IW'(s1_start_reg);
    assign frun_inc      = (frun_reg == '1) ? frun_reg : frun_reg + FAIL_W'(1);
    assign waddr         = IW'(s1_addr_reg);

    always_comb
    begin
        mode_next = mode_reg;
        cur_upd   = cur_reg;
        frun_next = frun_reg;
        upd_next  = upd_reg;
        mat_next  = mat_reg;
        mis_next  = mis_reg;
        vres_next = 1'b0;
        wr_en     = 1'b0;
        case (s1_kind_reg)
            KIND_TRACK:
            begin
                if (mode_reg != MODE_UNINIT)
                    upd_next = upd_reg + CNT_W'(1);
                if (mode_reg == MODE_TRACK)
                begin
                    if (exp_bit == s1_bit_reg)
                    begin
                        cur_upd   = s1_pred_reg;
                        frun_next = '0;
                        mat_next  = mat_reg + CNT_W'(1);
                        vres_next = 1'b1;
                    end
                    else
                    begin
                        frun_next = frun_inc;
                        mis_next  = mis_reg + CNT_W'(1);
                        if (frun_inc >= maxf_reg)
                            mode_next = MODE_LOST;
                    end
                end
            end
            KIND_START:
            begin
                cur_upd   = start_clamped;
                mode_next = MODE_TRACK;
                frun_next = '0;
            end
            KIND_RESET:
            begin
                mode_next = MODE_UNINIT;
                cur_upd   = '0;
                frun_next = '0;
            end
            KIND_WRITE:
                wr_en = fire && (32'(s1_addr_reg) < 32'(PATTERN_DEPTH));
            KIND_CLEAR:
            begin
                upd_next = '0;
                mat_next = '0;
                mis_next = '0;
            end
            default: ;
        endcase
    end

    // shrinking the length pulls the position back inside it unless a beat fires
    always_comb
    begin
        if (fire)
            cur_next = cur_upd;
        else if (len_wr && (cur_reg > cfg_last))
            cur_next = cfg_last;
        else
            cur_next = cur_reg;
    end

    ppt_predict #(
        .IW (IW)
    ) u_predict (
        .cur  (cur_next),
        .last (last_reg),
        .ring (ring_reg),
        .back (req.direction),
        .pred (pred)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_UNINIT;
            cur_reg  <= '0;
            frun_reg <= '0;
            upd_reg  <= '0;
            mat_reg  <= '0;
            mis_reg  <= '0;
        end
        else
        begin
            cur_reg <= cur_next;
            if (fire)
            begin
                mode_reg <= mode_next;
                frun_reg <= frun_next;
                upd_reg  <= upd_next;
                mat_reg  <= mat_next;
                mis_reg  <= mis_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            pattern_ram[waddr] <= s1_pval_reg;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rd_bit_reg   <= pattern_ram[pred];
            byp_hit_reg  <= wr_en && (waddr == pred);
            byp_bit_reg  <= s1_pval_reg;
            s1_kind_reg  <= req.kind;
            s1_bit_reg   <= req.sensed_bit;
            s1_start_reg <= req.start_position;
            s1_addr_reg  <= req.pattern_address;
            s1_pval_reg  <= req.pattern_value;
            s1_pred_reg  <= pred;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
                s1_valid_reg <= 1'b1;
            else if (fire)
                s1_valid_reg <= 1'b0;

            if (fire)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            vres_reg <= vres_next;
    end

    // mode, failure run and counters only move when a result beat is loaded
    always_comb
    begin
        unique case (mode_reg)
            MODE_UNINIT: rsp.tracker_state = ST_UNINIT;
            MODE_TRACK:  rsp.tracker_state = ST_TRACK;
            MODE_LOST:   rsp.tracker_state = ST_LOST;
            default:     rsp.tracker_state = ST_UNINIT;
        endcase
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.valid_res      = vres_reg;
    assign rsp.position       = POS_W'(cur_reg);
    assign rsp.update_total   = upd_reg;
    assign rsp.match_total    = mat_reg;
    assign rsp.mismatch_total = mis_reg;

endmodule

// ===== src/ppt_predict.sv =====
// ppt_predict: next position along the pattern from the current one,
// wrapping in ring mode and holding at the ends otherwise.
// Depends on ppt_pkg for the default width; pure combinational.
module ppt_predict
    import ppt_pkg::*;
#(
    parameter int IW = $clog2(PATTERN_DEPTH_DEF)
)
(
    input  logic [IW-1:0] cur,
    input  logic [IW-1:0] last,
    input  logic          ring,
    input  logic          back,
    output logic [IW-1:0] pred
);

    logic at_top;
    logic at_bottom;

    assign at_top    = (cur >= last);
    assign at_bottom = (cur == '0);

    always_comb
    begin
        if (!back)
        begin
            if (at_top)
                pred = ring ? '0 : cur;
            else
                pred = cur + IW'(1);
        end
        else
        begin
            if (at_bottom)
                pred = ring ? last : cur;
            else
                pred = cur - IW'(1);
        end
    end

endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for pattern_position_tracker, with random stalls on both channels
// holds its own copy of the tracker state and compares every result beat field by field
// depends on ppt_pkg, ppt_req_if / ppt_rsp_if and the tracker rtl
module tb;
    import ppt_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int SETTLE_CYCLES    = 4;
    localparam int IDLE_PCT         = 10;
    localparam int CALM_FROM        = 300;
    localparam int CALM_TO          = 900;
    localparam int REPORT_LIMIT     = 10;
    localparam int KIND_SPARE_FIRST = 5;
    localparam int KIND_SPARE_LAST  = 7;

    // index past the register list, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              sensed_bit;
        logic              direction;
        logic [POS_W-1:0]  start_position;
        logic [ADDR_W-1:0] pattern_address;
        logic              pattern_value;
    } track_cmd_t;

    typedef struct packed {
        logic               valid_res;
        logic [POS_W-1:0]   position;
        logic [STATE_W-1:0] tracker_state;
        logic [CNT_W-1:0]   update_total;
        logic [CNT_W-1:0]   match_total;
        logic [CNT_W-1:0]   mismatch_total;
    } track_report_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b1;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    int unsigned          cycle_count = 0;
    int                   fault_count = 0;
    logic                 calm;

    ppt_req_if req_ch();
    ppt_rsp_if rsp_ch();

    pattern_position_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    track_cmd_t    pending_beats[$];
    track_report_t expected_reports[$];

    // tracker copy
    logic               m_ring = RING_RST;
    logic [LEN_W-1:0]   m_len = LEN_W'(LEN_RST);
    logic [FAIL_W-1:0]  m_maxf = MAXF_RST;
    logic [STATE_W-1:0] m_state = ST_UNINIT;
    logic [POS_W-1:0]   m_pos = '0;
    logic [FAIL_W-1:0]  m_fails = '0;
    logic [CNT_W-1:0]   m_updates = '0;
    logic [CNT_W-1:0]   m_matches = '0;
    logic [CNT_W-1:0]   m_misses = '0;
    bit                 m_pattern [PATTERN_DEPTH_DEF];
    bit                 m_known   [PATTERN_DEPTH_DEF];
    bit                 heading = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

    function automatic int unsigned live_length();
        if (m_len == '0)
            return 1;
        if (m_len > LEN_W'(PATTERN_DEPTH_DEF))
            return PATTERN_DEPTH_DEF;
        return 32'(m_len);
    endfunction

    function automatic int unsigned next_index(bit backward);
        int unsigned len;
        int unsigned cur;
        len = live_length();
        cur = 32'(m_pos);
        if (m_ring)
        begin
            if (!backward)
                return (cur + 1) % len;
            return (cur == 0) ? len - 1 : cur - 1;
        end
        if (!backward)
            return (cur + 1 < len) ? cur + 1 : cur;
        return (cur > 0) ? cur - 1 : cur;
    endfunction

    function automatic track_report_t advance_tracker(track_cmd_t c);
        int unsigned   len;
        int unsigned   nxt;
        track_report_t r;
        len = live_length();
        r.valid_res = 1'b0;
        case (c.kind)
            KIND_TRACK:
            begin
                if (m_state != ST_UNINIT)
                begin
                    m_updates = m_updates + 1'b1;
                    if (m_state == ST_TRACK)
                    begin
                        nxt = next_index(c.direction);
                        if (m_pattern[nxt] == c.sensed_bit)
                        begin
                            m_pos = POS_W'(nxt);
                            m_fails = '0;
                            m_matches = m_matches + 1'b1;
                            r.valid_res = 1'b1;
                        end
                        else
                        begin
                            if (m_fails != '1)
                                m_fails = m_fails + 1'b1;
                            m_misses = m_misses + 1'b1;
                            if (m_fails >= m_maxf)
                                m_state = ST_LOST;
                        end
                    end
                end
            end
            KIND_START:
            begin
                m_pos = (32'(c.start_position) >= len) ? POS_W'(len - 1) : c.start_position;
                m_state = ST_TRACK;
                m_fails = '0;
            end
            KIND_RESET:
            begin
                m_state = ST_UNINIT;
                m_pos = '0;
                m_fails = '0;
            end
            KIND_WRITE:
            begin
                m_pattern[c.pattern_address] = c.pattern_value;
                m_known[c.pattern_address] = 1'b1;
            end
            KIND_CLEAR:
            begin
                m_updates = '0;
                m_matches = '0;
                m_misses = '0;
            end
            default:
            begin
            end
        endcase
        r.position = m_pos;
        r.tracker_state = m_state;
        r.update_total = m_updates;
        r.match_total = m_matches;
        r.mismatch_total = m_misses;
        return r;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        case (idx)
            REG_RING:
                m_ring = value[0];
            REG_LEN:
            begin
                m_len = value[LEN_W-1:0];
                // shrinking the length pulls the position back inside
                if (32'(m_pos) >= live_length())
                    m_pos = POS_W'(live_length() - 1);
            end
            REG_MAXF:
                m_maxf = value[FAIL_W-1:0];
            default:
            begin
            end
        endcase
    endfunction

    function automatic track_cmd_t scrambled_cmd(logic [KIND_W-1:0] k);
        track_cmd_t c;
        c.kind = k;
        c.sensed_bit = 1'($urandom);
        c.direction = 1'($urandom);
        c.start_position = POS_W'($urandom);
        c.pattern_address = ADDR_W'($urandom);
        c.pattern_value = 1'($urandom);
        return c;
    endfunction

    task automatic emit(track_cmd_t c);
        pending_beats.push_back(c);
        expected_reports.push_back(advance_tracker(c));
    endtask

    task automatic emit_write(int unsigned addr, bit value);
        track_cmd_t c;
        c = scrambled_cmd(KIND_WRITE);
        c.pattern_address = ADDR_W'(addr);
        c.pattern_value = value;
        emit(c);
    endtask

    task automatic emit_start(int unsigned where);
        track_cmd_t c;
        c = scrambled_cmd(KIND_START);
        c.start_position = POS_W'(where);
        emit(c);
    endtask

    // an unwritten pattern entry is never read: it gets written just before
    task automatic emit_track(bit backward, bit hit);
        track_cmd_t  c;
        int unsigned nxt;
        c = scrambled_cmd(KIND_TRACK);
        c.direction = backward;
        if (m_state == ST_TRACK)
        begin
            nxt = next_index(backward);
            if (!m_known[nxt])
                emit_write(nxt, 1'($urandom));
            c.sensed_bit = hit ? m_pattern[nxt] : !m_pattern[nxt];
        end
        emit(c);
    endtask

    task automatic emit_random();
        track_cmd_t  c;
        int unsigned pick;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 8)
            heading = !heading;
        if (m_state == ST_UNINIT && pick < 50)
            pick = 75;
        if (pick < 72)
            emit_track(heading, $urandom_range(99) < 85);
        else if (pick < 80)
        begin
            c = scrambled_cmd(KIND_START);
            if ($urandom_range(1) == 1)
                c.start_position = POS_W'($urandom_range(live_length() - 1));
            emit(c);
        end
        else if (pick < 88)
        begin
            c = scrambled_cmd(KIND_WRITE);
            if ($urandom_range(99) < 60)
                c.pattern_address = ADDR_W'($urandom_range(live_length() - 1));
            emit(c);
        end
        else if (pick < 92)
            emit(scrambled_cmd(KIND_RESET));
        else if (pick < 96)
            emit(scrambled_cmd(KIND_CLEAR));
        else
            emit(scrambled_cmd(KIND_W'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST))));
    endtask

    task automatic run_random(int count);
        repeat (count) emit_random();
    endtask

    task automatic drain();
        while (pending_beats.size() != 0 || expected_reports.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        apply_reg(idx, value);
        @(negedge clk);
    endtask

    task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
        if (got !== want)
        begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
                $display("mismatch on %s at cycle %0d: expected %0h, got %0h",
                         name, cycle_count, want, got);
        end
    endtask

    // driver: a stalled beat is held, otherwise the next one goes out unless idling
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.kind <= '0;
            req_ch.sensed_bit <= 1'b0;
            req_ch.direction <= 1'b0;
            req_ch.start_position <= '0;
            req_ch.pattern_address <= '0;
            req_ch.pattern_value <= 1'b0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (req_ch.valid)
                pending_beats.delete(0);
            if (pending_beats.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                req_ch.valid <= 1'b1;
                req_ch.kind <= pending_beats[0].kind;
                req_ch.sensed_bit <= pending_beats[0].sensed_bit;
                req_ch.direction <= pending_beats[0].direction;
                req_ch.start_position <= pending_beats[0].start_position;
                req_ch.pattern_address <= pending_beats[0].pattern_address;
                req_ch.pattern_value <= pending_beats[0].pattern_value;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : monitor
        track_report_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("result beat with nothing expected at cycle %0d: position %0h",
                                 cycle_count, rsp_ch.position);
                end
                else
                begin
                    want = expected_reports[0];
                    expected_reports.delete(0);
                    check_field("valid_res", CNT_W'(want.valid_res), CNT_W'(rsp_ch.valid_res));
                    check_field("position", CNT_W'(want.position), CNT_W'(rsp_ch.position));
                    check_field("tracker_state", CNT_W'(want.tracker_state),
                                CNT_W'(rsp_ch.tracker_state));
                    check_field("update_total", want.update_total, rsp_ch.update_total);
                    check_field("match_total", want.match_total, rsp_ch.match_total);
                    check_field("mismatch_total", want.mismatch_total, rsp_ch.mismatch_total);
                end
            end
            rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;

        // directed part, reset register values
        emit(scrambled_cmd(KIND_TRACK));
        emit(scrambled_cmd(KIND_W'(KIND_SPARE_FIRST)));
        emit(scrambled_cmd(KIND_W'(KIND_SPARE_FIRST + 1)));
        emit(scrambled_cmd(KIND_W'(KIND_SPARE_LAST)));
        emit(scrambled_cmd(KIND_CLEAR));
        emit_write(PATTERN_DEPTH_DEF - 1, 1'b1);
        emit_write(0, 1'b0);
        emit_write(1, 1'b1);
        emit_write(PATTERN_DEPTH_DEF - 2, 1'b0);
        emit_start(PATTERN_DEPTH_DEF - 1);
        emit_track(1'b0, 1'b1);
        emit_track(1'b1, 1'b1);
        emit_track(1'b1, 1'b1);
        emit_track(1'b0, 1'b1);
        repeat (3) emit_track(1'b0, 1'b0);
        emit_track(1'b0, 1'b1);
        emit_start(0);
        emit_track(1'b0, 1'b1);
        emit(scrambled_cmd(KIND_CLEAR));
        emit(scrambled_cmd(KIND_RESET));
        emit_track(1'b1, 1'b1);
        emit_start(0);
        emit_track(1'b1, 1'b0);
        emit_track(1'b1, 1'b1);
        repeat (2) emit_track(1'b0, 1'b0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        run_random(150);

        // linear mode, short pattern, lost on the first mismatch
        set_reg(REG_RING, CFG_W'(0));
        set_reg(REG_LEN, CFG_W'(16));
        set_reg(REG_MAXF, CFG_W'(1));
        run_random(170);
        emit_start(13);

        // one-bit pattern, longest failure run
        set_reg(REG_LEN, CFG_W'(1));
        set_reg(REG_MAXF, CFG_W'(255));
        set_reg(REG_RING, CFG_W'(1));
        emit_start($urandom_range(PATTERN_DEPTH_DEF - 1));
        repeat (256) emit_track(1'($urandom), 1'b0);
        run_random(40);

        // length above the depth, zero failure limit
        set_reg(REG_RING, CFG_W'(0));
        set_reg(REG_LEN, CFG_W'(2047));
        set_reg(REG_MAXF, CFG_W'(0));
        run_random(130);

        // zero length, write to a missing register
        set_reg(REG_LEN, CFG_W'(0));
        set_reg(REG_MAXF, CFG_W'(4));
        set_reg(REG_RING, CFG_W'(1));
        set_reg(REG_SPARE, CFG_W'(11'h5A5));
        run_random(80);

        set_reg(REG_LEN, CFG_W'(33));
        set_reg(REG_MAXF, CFG_W'(3));
        set_reg(REG_RING, CFG_W'(0));
        run_random(150);

        drain();
        repeat (SETTLE_CYCLES * 4) @(posedge clk);
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
